// ----- rtl/mme_pkg.sv -----
// Shared types and constants for the matrix multiply engine.
// Used by mme_ctrl, mme_dp and matrix_multiply_engine; depends on nothing else.
package mme_pkg;

   localparam int MAX_DIM  = 16;
   localparam int KIND_W   = 2;
   localparam int IDX_W    = 4;
   localparam int VAL_W    = 16;
   localparam int SIZE_W   = 5;
   localparam int PROD_W   = 2 * VAL_W;
   localparam int ACC_W    = PROD_W + SIZE_W;
   localparam int FRAC_W   = 8;
   localparam int ADDR_W   = 4;
   localparam int REG_IDX_W = 2;
   localparam int DATA_W   = 32;

   localparam logic [KIND_W-1:0] KIND_WRITE_A = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE_B = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

   localparam logic [REG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_INNER_LEN = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_COLS_B    = 2'd2;

   localparam logic [VAL_W-1:0] Q_MAX = 16'h7fff;
   localparam logic [VAL_W-1:0] Q_MIN = 16'h8000;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   typedef struct packed {
      logic write_a;
      logic write_b;
      logic load;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic wr_a_ok;
      logic wr_b_ok;
      logic cmp_ok;
      logic last_k;
      logic pipe_empty;
   } status_type;

endpackage

// ----- rtl/matrix_multiply_engine.sv -----
// Matrix multiply engine: a store write leaves busy low, so writes go back to back.
// An in-range compute keeps busy high through the walk and the read, multiply and
// accumulate stages; its result is taken when busy falls, which is also the earliest next
// acceptance. An out-of-range compute keeps busy high for one cycle, and its result is
// taken when busy falls. Reset clears control state and sets each size to 16; store
// contents are not cleared. Results cannot be held off by the receiver.
module matrix_multiply_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [mme_pkg::KIND_W-1:0]        req_kind,
   input  logic [mme_pkg::IDX_W-1:0]         req_row_index,
   input  logic [mme_pkg::IDX_W-1:0]         req_col_index,
   input  logic signed [mme_pkg::VAL_W-1:0]  req_element_value,
   output logic                              rsp_strobe,
   output logic signed [mme_pkg::VAL_W-1:0]  rsp_product_value,
   output logic [mme_pkg::IDX_W-1:0]         rsp_out_row,
   output logic [mme_pkg::IDX_W-1:0]         rsp_out_col,
   output logic                              rsp_saturated,
   output logic                              rsp_index_error,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [mme_pkg::ADDR_W-1:0]        paddr,
   input  logic [mme_pkg::DATA_W-1:0]        pwdata,
   output logic [mme_pkg::DATA_W-1:0]        prdata,
   output logic                              pready
);
   import mme_pkg::*;

   localparam int SIZE_RST_INT = (MAX_DIM < 16) ? MAX_DIM : 16;
   localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(SIZE_RST_INT);

   logic [SIZE_W-1:0]    rows_a_ff, rows_a_in;
   logic [SIZE_W-1:0]    inner_len_ff, inner_len_in;
   logic [SIZE_W-1:0]    cols_b_ff, cols_b_in;
   logic                 csr_write;
   logic [REG_IDX_W-1:0] csr_index;
   logic [SIZE_W-1:0]    csr_size;
   cmd_type              cmd;
   status_type           status;

   // A size below one is held as one, above MAX_DIM as MAX_DIM.
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (32'(v) > 32'(MAX_DIM)) begin
         r = SIZE_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[REG_IDX_W+1:2];
   assign csr_size  = clamp_size(pwdata[SIZE_W-1:0]);

   always_comb begin
      rows_a_in    = rows_a_ff;
      inner_len_in = inner_len_ff;
      cols_b_in    = cols_b_ff;
      if (csr_write) begin
         case (csr_index)
            REG_ROWS_A:    rows_a_in    = csr_size;
            REG_INNER_LEN: inner_len_in = csr_size;
            REG_COLS_B:    cols_b_in    = csr_size;
            default: begin
               rows_a_in = rows_a_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= SIZE_RST;
         inner_len_ff <= SIZE_RST;
         cols_b_ff    <= SIZE_RST;
      end else begin
         rows_a_ff    <= rows_a_in;
         inner_len_ff <= inner_len_in;
         cols_b_ff    <= cols_b_in;
      end
   end

   always_comb begin
      case (csr_index)
         REG_ROWS_A:    prdata = DATA_W'(rows_a_ff);
         REG_INNER_LEN: prdata = DATA_W'(inner_len_ff);
         REG_COLS_B:    prdata = DATA_W'(cols_b_ff);
         default:       prdata = '0;
      endcase
   end

   mme_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   mme_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .rows_a            (rows_a_ff),
      .inner_len         (inner_len_ff),
      .cols_b            (cols_b_ff),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .cmd               (cmd),
      .status            (status),
      .rsp_product_value (rsp_product_value),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_saturated     (rsp_saturated),
      .rsp_index_error   (rsp_index_error),
      .rsp_strobe        (rsp_strobe)
   );

   // Two results can never come in adjacent cycles.
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe in two adjacent cycles");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_index_error) |-> (rsp_product_value == '0 && !rsp_saturated))
      else $error("index error result carries a value or saturation");

   a_cmd_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.write_a, cmd.write_b, cmd.load, cmd.step, cmd.finish}))
      else $error("more than one datapath command at once");

   a_write_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind != KIND_COMPUTE) |=> !busy)
      else $error("store write request left the engine busy");

endmodule

// ----- rtl/mme_ctrl.sv -----
// Controller state machine of the matrix multiply engine.
// Depends on mme_pkg; drives the command struct of mme_dp from its status.
module mme_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mme_pkg::KIND_W-1:0]    req_kind,
   input  mme_pkg::status_type           status,
   output logic                          busy,
   output mme_pkg::cmd_type              cmd
);
   import mme_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_kind)
                  KIND_WRITE_A: begin
                     cmd.write_a = status.wr_a_ok;
                  end
                  KIND_WRITE_B: begin
                     cmd.write_b = status.wr_b_ok;
                  end
                  KIND_COMPUTE: begin
                     cmd.load = 1'b1;
                     // An out-of-range request skips the walk and reports at once.
                     state_in = status.cmp_ok ? ST_RUN : ST_DRAIN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (status.last_k) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.pipe_empty) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ----- rtl/mme_dp.sv -----
// Datapath of the matrix multiply engine: A and B stores, multiply-accumulate
// pipeline and result register. Depends on mme_pkg; steered by mme_ctrl.
module mme_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [mme_pkg::SIZE_W-1:0]        rows_a,
   input  logic [mme_pkg::SIZE_W-1:0]        inner_len,
   input  logic [mme_pkg::SIZE_W-1:0]        cols_b,
   input  logic [mme_pkg::IDX_W-1:0]         req_row_index,
   input  logic [mme_pkg::IDX_W-1:0]         req_col_index,
   input  logic signed [mme_pkg::VAL_W-1:0]  req_element_value,
   input  mme_pkg::cmd_type                  cmd,
   output mme_pkg::status_type               status,
   output logic signed [mme_pkg::VAL_W-1:0]  rsp_product_value,
   output logic [mme_pkg::IDX_W-1:0]         rsp_out_row,
   output logic [mme_pkg::IDX_W-1:0]         rsp_out_col,
   output logic                              rsp_saturated,
   output logic                              rsp_index_error,
   output logic                              rsp_strobe
);
   import mme_pkg::*;

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);

   logic signed [VAL_W-1:0]  a_store_ff [DEPTH];
   logic signed [VAL_W-1:0]  b_store_ff [DEPTH];

   logic [IDX_W-1:0]         row_ff, col_ff;
   logic                     err_ff;
   logic [SIZE_W-1:0]        k_ff, k_in;
   logic                     rd_vld_ff, mul_vld_ff;
   logic signed [VAL_W-1:0]  a_q_ff, b_q_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [ACC_W-1:0]         acc_ff, acc_in;

   logic [AW-1:0]            wr_addr, a_rd_addr, b_rd_addr;
   logic [SIZE_W-1:0]        row_ext, col_ext;
   logic                     sat_pos, sat_neg;
   logic signed [VAL_W-1:0]  q_value;

   assign row_ext = {1'b0, req_row_index};
   assign col_ext = {1'b0, req_col_index};

   assign status.wr_a_ok    = (row_ext < rows_a) && (col_ext < inner_len);
   assign status.wr_b_ok    = (row_ext < inner_len) && (col_ext < cols_b);
   assign status.cmp_ok     = (row_ext < rows_a) && (col_ext < cols_b);
   assign status.last_k     = (k_ff == inner_len - SIZE_W'(1));
   assign status.pipe_empty = !rd_vld_ff && !mul_vld_ff;

   // Entry (r, c) of either store sits at r * MAX_DIM + c.
   assign wr_addr   = AW'(32'(req_row_index) * 32'(MAX_DIM) + 32'(req_col_index));
   assign a_rd_addr = AW'(32'(row_ff) * 32'(MAX_DIM) + 32'(k_ff));
   assign b_rd_addr = AW'(32'(k_ff) * 32'(MAX_DIM) + 32'(col_ff));

   always_ff @(posedge clock) begin
      if (cmd.write_a) begin
         a_store_ff[wr_addr] <= req_element_value;
      end
      a_q_ff <= a_store_ff[a_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.write_b) begin
         b_store_ff[wr_addr] <= req_element_value;
      end
      b_q_ff <= b_store_ff[b_rd_addr];
   end

   always_comb begin
      k_in = k_ff;
      if (cmd.load) begin
         k_in = '0;
      end else if (cmd.step) begin
         k_in = k_ff + SIZE_W'(1);
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.load) begin
         acc_in = '0;
      end else if (mul_vld_ff) begin
         acc_in = acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         row_ff <= req_row_index;
         col_ff <= req_col_index;
         err_ff <= !status.cmp_ok;
      end
      k_ff    <= k_in;
      prod_ff <= a_q_ff * b_q_ff;
      acc_ff  <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= cmd.step;
         mul_vld_ff <= rd_vld_ff;
      end
   end

   // After the arithmetic shift by FRAC_W the value fits Q8.8 only when every
   // bit from bit 15 up equals the sign.
   assign sat_pos = !acc_ff[ACC_W-1] && (|acc_ff[ACC_W-2:FRAC_W+VAL_W-1]);
   assign sat_neg = acc_ff[ACC_W-1] && !(&acc_ff[ACC_W-2:FRAC_W+VAL_W-1]);

   always_comb begin
      if (sat_pos) begin
         q_value = Q_MAX;
      end else if (sat_neg) begin
         q_value = Q_MIN;
      end else begin
         q_value = acc_ff[FRAC_W+VAL_W-1:FRAC_W];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_product_value <= err_ff ? '0 : q_value;
         rsp_saturated     <= !err_ff && (sat_pos || sat_neg);
         rsp_index_error   <= err_ff;
         rsp_out_row       <= row_ff;
         rsp_out_col       <= col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= cmd.finish;
      end
   end

endmodule
